// ===== rtl/sst_pkg.sv =====
`timescale 1ns / 1ps
// sst_pkg: shared types and constants for the scoped symbol table
// used by every module of the block but sst_ram, no dependencies

package sst_pkg;

    localparam int ACTION_W   = 2;
    localparam int NAME_KEY_W = 64;
    localparam int OFFSET_W   = 32;
    localparam int ADDR_W     = 33;
    localparam int STATUS_W   = 2;
    localparam int GBASE_W    = 31;
    localparam int SLOT_SHIFT = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [GBASE_W-1:0] GBASE_RESET = 31'h0040_1000;

    // word index of the register, taken from paddr[2]
    localparam logic REG_GLOBAL_BASE = 1'b0;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic                load;
        logic                scan;
        logic                finish;
        logic [STATUS_W-1:0] status;
    } sst_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                match;
        logic                scan_end;
        logic                hit;
        logic                depth_full;
        logic                total_full;
        logic                out_free;
    } sst_stat_t;

endpackage

// ===== rtl/sst_ram.sv =====
`timescale 1ns / 1ps
// sst_ram: generic single write port, single read port ram with registered read
// no dependencies

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sst_ctrl.sv =====
`timescale 1ns / 1ps
// sst_ctrl: controller state machine of the scoped symbol table
// depends on sst_pkg for the command and status structs

module sst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sst_pkg::sst_stat_t st,
    output sst_pkg::sst_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_OFFS   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       walks;

    assign walks    = (st.action == sst_pkg::ACT_ADD) || (st.action == sst_pkg::ACT_FIND);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = sst_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!walks)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (st.match)
                    begin
                        state_next = (st.action == sst_pkg::ACT_FIND) ? S_OFFS : S_FINISH;
                    end
                    else if (st.scan_end)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_OFFS:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                case (st.action)
                    sst_pkg::ACT_PUSH:
                        cmd.status = st.depth_full ? sst_pkg::ST_FULL : sst_pkg::ST_OK;
                    sst_pkg::ACT_ADD:
                        cmd.status = st.hit ? sst_pkg::ST_DUP :
                                     st.total_full ? sst_pkg::ST_FULL : sst_pkg::ST_OK;
                    sst_pkg::ACT_FIND:
                        cmd.status = st.hit ? sst_pkg::ST_OK : sst_pkg::ST_NOTFOUND;
                    default:
                        cmd.status = sst_pkg::ST_OK;
                endcase
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sst_dp.sv =====
`timescale 1ns / 1ps
// sst_dp: datapath of the scoped symbol table, scope registers, entry walk and result
// depends on sst_pkg and sst_ram

module sst_dp #(
    parameter int MAX_SCOPES = 16,
    parameter int MAX_NAMES  = 256,
    parameter int KEY_BITS   = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sst_pkg::GBASE_W-1:0]         global_base,
    input  logic [sst_pkg::ACTION_W-1:0]        action,
    input  logic [sst_pkg::NAME_KEY_W-1:0]      name_key,
    input  logic signed [sst_pkg::OFFSET_W-1:0] scope_offset,
    input  sst_pkg::sst_cmd_t                   cmd,
    output sst_pkg::sst_stat_t                  st,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [sst_pkg::STATUS_W-1:0]        status,
    output logic                                found_global,
    output logic signed [sst_pkg::ADDR_W-1:0]   address,
    output logic signed [sst_pkg::ADDR_W-1:0]   next_offset,
    output logic                                at_global
);

    localparam int SW = $clog2(MAX_SCOPES);
    localparam int DW = $clog2(MAX_SCOPES + 1);
    localparam int AW = $clog2(MAX_NAMES);
    localparam int CW = $clog2(MAX_NAMES + 1);
    localparam int EW = KEY_BITS + SW + AW;
    localparam int OW = sst_pkg::OFFSET_W;
    localparam int XW = sst_pkg::ADDR_W;
    localparam int GW = sst_pkg::GBASE_W;
    localparam int SH = sst_pkg::SLOT_SHIFT;

    logic [sst_pkg::ACTION_W-1:0] act_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic [OW-1:0]                soff_reg;
    logic [OW-1:0]                top_off_reg;
    logic [DW-1:0]                depth_reg;
    logic [CW-1:0]                total_reg;
    logic [CW-1:0]                top_cnt_reg;
    logic [AW-1:0]                ptr_reg;
    logic                         issue_reg;
    logic                         chk_vld_reg;
    logic                         hit_reg;
    logic [SW-1:0]                hit_scope_reg;
    logic [AW-1:0]                hit_index_reg;
    logic                         out_valid_reg;
    logic [sst_pkg::STATUS_W-1:0] status_reg;
    logic                         found_global_reg;
    logic [XW-1:0]                address_reg;
    logic [XW-1:0]                next_offset_reg;
    logic                         at_global_reg;

    logic [EW-1:0]       ent_rdata;
    logic [OW-1:0]       off_rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [SW-1:0]       rd_scope;
    logic [AW-1:0]       rd_index;
    logic [DW-1:0]       top_full;
    logic [SW-1:0]       top_scope;
    logic [CW-1:0]       total_m1;
    logic                match;
    logic                out_free;
    logic                push_ok;
    logic                add_ok;
    logic [DW-1:0]       new_depth;
    logic [OW-1:0]       new_top_off;
    logic [CW-1:0]       new_cnt;
    logic                new_at_global;
    logic [XW-1:0]       gbase_ext;
    logic [XW-1:0]       eff_off;
    logic [XW-1:0]       cnt_ext;
    logic [XW-1:0]       next_val;
    logic                found;
    logic [XW-1:0]       base_ext;
    logic [XW-1:0]       idx_ext;
    logic [XW-1:0]       addr_val;

    assign rd_key    = ent_rdata[EW-1 -: KEY_BITS];
    assign rd_scope  = ent_rdata[AW +: SW];
    assign rd_index  = ent_rdata[AW-1:0];
    assign top_full  = depth_reg - DW'(1);
    assign top_scope = top_full[SW-1:0];
    assign total_m1  = total_reg - CW'(1);

    assign match = chk_vld_reg && (rd_key == key_reg)
                   && ((act_reg == sst_pkg::ACT_FIND) || (rd_scope == top_scope));
    assign out_free = !out_valid_reg || out_ready;

    assign st.action     = act_reg;
    assign st.match      = match;
    assign st.scan_end   = !chk_vld_reg && !issue_reg;
    assign st.hit        = hit_reg;
    assign st.depth_full = (depth_reg == DW'(MAX_SCOPES));
    assign st.total_full = (total_reg == CW'(MAX_NAMES));
    assign st.out_free   = out_free;

    assign push_ok = cmd.finish && (cmd.status == sst_pkg::ST_OK)
                     && (act_reg == sst_pkg::ACT_PUSH);
    assign add_ok  = cmd.finish && (cmd.status == sst_pkg::ST_OK)
                     && (act_reg == sst_pkg::ACT_ADD);

    // state after this transaction, for next_offset and at_global
    assign new_depth     = push_ok ? depth_reg + DW'(1) : depth_reg;
    assign new_top_off   = push_ok ? soff_reg : top_off_reg;
    assign new_cnt       = push_ok ? '0 : (add_ok ? top_cnt_reg + CW'(1) : top_cnt_reg);
    assign new_at_global = (new_depth == DW'(1));

    assign gbase_ext = {{(XW-GW){1'b0}}, global_base};
    assign eff_off   = new_at_global ? gbase_ext : {{(XW-OW){new_top_off[OW-1]}}, new_top_off};
    assign cnt_ext   = {{(XW-CW-SH){1'b0}}, new_cnt, {SH{1'b0}}};
    assign next_val  = (!eff_off[XW-1] && (eff_off != '0)) ? eff_off + cnt_ext : '0;

    assign found    = (act_reg == sst_pkg::ACT_FIND) && hit_reg;
    assign base_ext = (hit_scope_reg == '0) ? gbase_ext
                                            : {{(XW-OW){off_rdata[OW-1]}}, off_rdata};
    assign idx_ext  = {{(XW-AW-SH){1'b0}}, hit_index_reg, {SH{1'b0}}};
    assign addr_val = found ? base_ext + idx_ext : '0;

    sst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NAMES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (add_ok),
        .waddr (total_reg[AW-1:0]),
        .wdata ({key_reg, top_scope, top_cnt_reg[AW-1:0]}),
        .raddr (ptr_reg),
        .rdata (ent_rdata)
    );

    sst_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_SCOPES)
    ) u_offset_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (depth_reg[SW-1:0]),
        .wdata (soff_reg),
        .raddr (hit_scope_reg),
        .rdata (off_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= DW'(1);
            total_reg     <= '0;
            top_cnt_reg   <= '0;
            issue_reg     <= 1'b0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                issue_reg   <= (total_reg != '0);
                chk_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                chk_vld_reg <= issue_reg;
                if (issue_reg)
                begin
                    issue_reg <= (ptr_reg != '0);
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            depth_reg   <= new_depth;
            top_cnt_reg <= new_cnt;
            if (add_ok)
            begin
                total_reg <= total_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            key_reg  <= name_key[KEY_BITS-1:0];
            soff_reg <= scope_offset;
            ptr_reg  <= total_m1[AW-1:0];
        end
        else if (cmd.scan)
        begin
            if (issue_reg)
            begin
                ptr_reg <= ptr_reg - AW'(1);
            end
            if (match)
            begin
                hit_scope_reg <= rd_scope;
                hit_index_reg <= rd_index;
            end
        end
        if (push_ok)
        begin
            top_off_reg <= soff_reg;
        end
        if (cmd.finish)
        begin
            status_reg       <= cmd.status;
            found_global_reg <= found && (hit_scope_reg == '0);
            address_reg      <= addr_val;
            next_offset_reg  <= next_val;
            at_global_reg    <= new_at_global;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_global = found_global_reg;
    assign address      = address_reg;
    assign next_offset  = next_offset_reg;
    assign at_global    = at_global_reg;

endmodule

// ===== rtl/scoped_symbol_table.sv =====
`timescale 1ns / 1ps
// Scoped symbol table. One transaction on the input channel gives exactly one result
// transaction. Push scope and query go from acceptance through the scan and finish
// states into the output register, as does any action while no name is stored. Add
// variable and find variable walk the stored name entries newest first, one entry per
// cycle through the registered read port of the entry ram, and stop at the first match;
// a find hit passes through an extra state reading the scope offset and never takes
// longer than a full walk. One transaction is processed at a time; the next is
// accepted as soon as the result sits in the output register, and a finished transaction
// waits while that register still holds an unaccepted result. No clearing pass after
// reset. global_base sits at byte address 0 of the apb port and takes effect at once.

module scoped_symbol_table #(
    parameter int MAX_SCOPES = 16,
    parameter int MAX_NAMES  = 256,
    parameter int KEY_BITS   = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sst_pkg::PADDR_W-1:0]         paddr,
    input  logic [sst_pkg::PDATA_W-1:0]         pwdata,
    output logic [sst_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sst_pkg::ACTION_W-1:0]        action,
    input  logic [sst_pkg::NAME_KEY_W-1:0]      name_key,
    input  logic signed [sst_pkg::OFFSET_W-1:0] scope_offset,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sst_pkg::STATUS_W-1:0]        status,
    output logic                                found_global,
    output logic signed [sst_pkg::ADDR_W-1:0]   address,
    output logic signed [sst_pkg::ADDR_W-1:0]   next_offset,
    output logic                                at_global
);

    logic [sst_pkg::GBASE_W-1:0] global_base_reg;
    logic                        cfg_wr;
    sst_pkg::sst_cmd_t           cmd;
    sst_pkg::sst_stat_t          st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == sst_pkg::REG_GLOBAL_BASE);
    assign prdata = (paddr[2] == sst_pkg::REG_GLOBAL_BASE)
                    ? {{(sst_pkg::PDATA_W-sst_pkg::GBASE_W){1'b0}}, global_base_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_base_reg <= sst_pkg::GBASE_RESET;
        end
        else if (cfg_wr)
        begin
            global_base_reg <= pwdata[sst_pkg::GBASE_W-1:0];
        end
    end

    sst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    sst_dp #(
        .MAX_SCOPES (MAX_SCOPES),
        .MAX_NAMES  (MAX_NAMES),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .global_base  (global_base_reg),
        .action       (action),
        .name_key     (name_key),
        .scope_offset (scope_offset),
        .cmd          (cmd),
        .st           (st),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .found_global (found_global),
        .address      (address),
        .next_offset  (next_offset),
        .at_global    (at_global)
    );

endmodule

// ===== rtl/sst_checker.sv =====
`timescale 1ns / 1ps
// sst_checker: port level assertions for the scoped symbol table, bound to the top level
// depends on sst_pkg and scoped_symbol_table

module sst_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [sst_pkg::STATUS_W-1:0]        status,
    input logic                                found_global,
    input logic signed [sst_pkg::ADDR_W-1:0]   address,
    input logic                                at_global
);

    // a pending result transaction is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != sst_pkg::ST_OK) |-> (address == '0) && !found_global)
        else $error("address or found_global set on a failed transaction");

    a_global_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_global |-> (status == sst_pkg::ST_OK))
        else $error("found_global without ok status");

    // scopes are never popped
    a_global_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !at_global |=> !at_global)
        else $error("at_global came back after a push");

    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted in back to back cycles");

endmodule

bind scoped_symbol_table sst_checker u_sst_checker (.*);

// ===== tb/sv/scoped_symbol_table_tb.sv =====
`timescale 1ns / 1ps
// scoped_symbol_table_tb: self-checking testbench for the scoped symbol table
// directed table then random transactions, every result checked against its table row or a local model
// depends on sst_pkg and the scoped_symbol_table rtl

module scoped_symbol_table_tb;

    localparam int MAX_SCOPES  = 16;
    localparam int MAX_NAMES   = 256;
    localparam int KEY_BITS    = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam logic [sst_pkg::PADDR_W-1:0] GBASE_ADDR = {sst_pkg::REG_GLOBAL_BASE, 2'b00};

    localparam logic [sst_pkg::NAME_KEY_W-1:0]      KEY_LO  = '0;
    localparam logic [sst_pkg::NAME_KEY_W-1:0]      KEY_HI  = '1;
    localparam logic signed [sst_pkg::OFFSET_W-1:0] OFF_MIN = 32'sh8000_0000;
    localparam logic signed [sst_pkg::OFFSET_W-1:0] OFF_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [sst_pkg::STATUS_W-1:0]      status;
        logic                              found_global;
        logic signed [sst_pkg::ADDR_W-1:0] address;
        logic signed [sst_pkg::ADDR_W-1:0] next_offset;
        logic                              at_global;
    } lookup_result_t;

    typedef struct {
        logic [sst_pkg::ACTION_W-1:0]        action;
        logic [sst_pkg::NAME_KEY_W-1:0]      key;
        logic signed [sst_pkg::OFFSET_W-1:0] offset;
        bit                                  typed;
        lookup_result_t                      result;
    } plan_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [sst_pkg::PADDR_W-1:0]         paddr;
    logic [sst_pkg::PDATA_W-1:0]         pwdata;
    logic [sst_pkg::PDATA_W-1:0]         prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_ready;
    logic [sst_pkg::ACTION_W-1:0]        action;
    logic [sst_pkg::NAME_KEY_W-1:0]      name_key;
    logic signed [sst_pkg::OFFSET_W-1:0] scope_offset;
    logic                                out_valid;
    logic                                out_ready;
    logic [sst_pkg::STATUS_W-1:0]        status;
    logic                                found_global;
    logic signed [sst_pkg::ADDR_W-1:0]   address;
    logic signed [sst_pkg::ADDR_W-1:0]   next_offset;
    logic                                at_global;

    // model state
    logic [sst_pkg::GBASE_W-1:0]         gbase_model;
    logic signed [sst_pkg::OFFSET_W-1:0] frame_base [MAX_SCOPES];
    int                                  frame_vars [MAX_SCOPES];
    int                                  open_scopes;
    logic [sst_pkg::NAME_KEY_W-1:0]      name_keys [MAX_NAMES];
    int                                  name_scope [MAX_NAMES];
    int                                  name_slot [MAX_NAMES];
    int                                  names_used;

    lookup_result_t                      pending_results [$];
    logic [sst_pkg::NAME_KEY_W-1:0]      key_pool [$];
    int                                  mismatch_count;
    bit                                  idle_on;

    scoped_symbol_table #(
        .MAX_SCOPES (MAX_SCOPES),
        .MAX_NAMES  (MAX_NAMES),
        .KEY_BITS   (KEY_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .name_key     (name_key),
        .scope_offset (scope_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_global (found_global),
        .address      (address),
        .next_offset  (next_offset),
        .at_global    (at_global)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic clear_table();
        int i;
        gbase_model = sst_pkg::GBASE_RESET;
        for (i = 0; i < MAX_SCOPES; i++)
        begin
            frame_base[i] = '0;
            frame_vars[i] = 0;
        end
        open_scopes = 1;
        names_used  = 0;
    endtask

    function automatic longint scope_base(input int scope);
        if (scope == 0)
            return longint'({1'b0, gbase_model});
        return longint'(frame_base[scope]);
    endfunction

    function automatic int find_name(input int scope,
                                     input logic [sst_pkg::NAME_KEY_W-1:0] key);
        int i;
        for (i = 0; i < names_used; i++)
            if (name_scope[i] == scope && name_keys[i] == key)
                return i;
        return -1;
    endfunction

    task automatic table_step(input logic [sst_pkg::ACTION_W-1:0] act,
                              input logic [sst_pkg::NAME_KEY_W-1:0] key,
                              input logic signed [sst_pkg::OFFSET_W-1:0] off,
                              output lookup_result_t res);
        int     top;
        int     s;
        int     hit;
        longint sum;
        res = '{default: '0};
        top = open_scopes - 1;
        case (act)
            sst_pkg::ACT_PUSH:
                if (open_scopes >= MAX_SCOPES)
                    res.status = sst_pkg::ST_FULL;
                else
                begin
                    frame_base[open_scopes] = off;
                    frame_vars[open_scopes] = 0;
                    open_scopes++;
                end
            sst_pkg::ACT_ADD:
                if (find_name(top, key) >= 0)
                    res.status = sst_pkg::ST_DUP;
                else if (names_used >= MAX_NAMES)
                    res.status = sst_pkg::ST_FULL;
                else
                begin
                    name_keys[names_used]  = key;
                    name_scope[names_used] = top;
                    name_slot[names_used]  = frame_vars[top];
                    frame_vars[top]++;
                    names_used++;
                end
            sst_pkg::ACT_FIND:
            begin
                // innermost scope first, first hit wins
                res.status = sst_pkg::ST_NOTFOUND;
                s = open_scopes;
                while (s > 0 && res.status == sst_pkg::ST_NOTFOUND)
                begin
                    hit = find_name(s - 1, key);
                    if (hit >= 0)
                    begin
                        res.status       = sst_pkg::ST_OK;
                        res.found_global = (s == 1);
                        sum = scope_base(s - 1)
                              + (longint'(name_slot[hit]) << sst_pkg::SLOT_SHIFT);
                        res.address = sum[sst_pkg::ADDR_W-1:0];
                    end
                    s--;
                end
            end
            sst_pkg::ACT_QUERY: ;
            default: ;
        endcase
        top = open_scopes - 1;
        if (scope_base(top) > 0)
        begin
            sum = scope_base(top) + (longint'(frame_vars[top]) << sst_pkg::SLOT_SHIFT);
            res.next_offset = sum[sst_pkg::ADDR_W-1:0];
        end
        res.at_global = (top == 0);
    endtask

    function automatic plan_row_t step_row(input logic [sst_pkg::ACTION_W-1:0] act,
                                           input logic [sst_pkg::NAME_KEY_W-1:0] key,
                                           input logic signed [sst_pkg::OFFSET_W-1:0] off);
        plan_row_t row;
        row.action = act;
        row.key    = key;
        row.offset = off;
        row.typed  = 1'b0;
        row.result = '{default: '0};
        return row;
    endfunction

    function automatic plan_row_t known_row(input logic [sst_pkg::ACTION_W-1:0] act,
                                            input logic [sst_pkg::NAME_KEY_W-1:0] key,
                                            input logic signed [sst_pkg::OFFSET_W-1:0] off,
                                            input logic [sst_pkg::STATUS_W-1:0] st,
                                            input logic fg,
                                            input logic signed [sst_pkg::ADDR_W-1:0] addr,
                                            input logic signed [sst_pkg::ADDR_W-1:0] nxt,
                                            input logic atg);
        plan_row_t row;
        row        = step_row(act, key, off);
        row.typed  = 1'b1;
        row.result = '{st, fg, addr, nxt, atg};
        return row;
    endfunction

    function automatic logic [sst_pkg::NAME_KEY_W-1:0] pick_key();
        logic [sst_pkg::NAME_KEY_W-1:0] k;
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = {$urandom(), $urandom()};
        if (key_pool.size() < 96)
            key_pool.push_back(k);
        return k;
    endfunction

    function automatic logic signed [sst_pkg::OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 9))
            0: return OFF_MIN;
            1: return OFF_MAX;
            2: return -1;
            3: return 0;
            4, 5, 6: return $urandom_range(1, 65536) * 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_action(input logic [sst_pkg::ACTION_W-1:0] act,
                               input logic [sst_pkg::NAME_KEY_W-1:0] key,
                               input logic signed [sst_pkg::OFFSET_W-1:0] off,
                               input bit typed,
                               input lookup_result_t typed_res);
        int             gap;
        lookup_result_t res;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        action       <= act;
        name_key     <= key;
        scope_offset <= off;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        table_step(act, key, off, res);
        if (typed)
            pending_results.push_back(typed_res);
        else
            pending_results.push_back(res);
    endtask

    task automatic run_random(input int count, input int w_push, input int w_add,
                              input int w_find);
        int                           roll;
        logic [sst_pkg::ACTION_W-1:0] act;
        lookup_result_t               blank;
        blank = '{default: '0};
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < w_push)
                act = sst_pkg::ACT_PUSH;
            else if (roll < w_push + w_add)
                act = sst_pkg::ACT_ADD;
            else if (roll < w_push + w_add + w_find)
                act = sst_pkg::ACT_FIND;
            else
                act = sst_pkg::ACT_QUERY;
            send_action(act, pick_key(), pick_offset(), 1'b0, blank);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // setup and access phase for the write, then a read back
    task automatic write_base(input logic [sst_pkg::GBASE_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GBASE_ADDR;
        pwdata  <= {1'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        gbase_model = value;
        frame_base[0] = {1'b0, value};
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== {1'b0, value})
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("global_base read back: expected %0h, got %0h", value, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result transaction: status %0d address %0d",
                             status, address);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== status || want.found_global !== found_global ||
                    want.address !== address || want.next_offset !== next_offset ||
                    want.at_global !== at_global)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"result mismatch: expected status %0d global %0d ",
                                  "address %0d next %0d at_global %0d, got %0d %0d %0d %0d %0d"},
                                 want.status, want.found_global, want.address,
                                 want.next_offset, want.at_global, status, found_global,
                                 address, next_offset, at_global);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t plan [$];
        int        i;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        action         = sst_pkg::ACT_QUERY;
        name_key       = '0;
        scope_offset   = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        clear_table();
        for (i = 0; i < 48; i++)
            key_pool.push_back({$urandom(), $urandom()});
        key_pool.push_back(KEY_LO);
        key_pool.push_back(KEY_HI);

        // global scope, reset base
        plan.push_back(known_row(sst_pkg::ACT_QUERY, KEY_LO, 0, sst_pkg::ST_OK, 0, 0,
                                 33'h0040_1000, 1));
        plan.push_back(known_row(sst_pkg::ACT_FIND, KEY_LO, 0, sst_pkg::ST_NOTFOUND, 0, 0,
                                 33'h0040_1000, 1));
        plan.push_back(known_row(sst_pkg::ACT_ADD, KEY_LO, 0, sst_pkg::ST_OK, 0, 0,
                                 33'h0040_1008, 1));
        plan.push_back(known_row(sst_pkg::ACT_ADD, KEY_LO, 0, sst_pkg::ST_DUP, 0, 0,
                                 33'h0040_1008, 1));
        plan.push_back(known_row(sst_pkg::ACT_ADD, KEY_HI, OFF_MAX, sst_pkg::ST_OK, 0, 0,
                                 33'h0040_1010, 1));
        plan.push_back(known_row(sst_pkg::ACT_FIND, KEY_LO, 0, sst_pkg::ST_OK, 1,
                                 33'h0040_1000, 33'h0040_1010, 1));
        plan.push_back(known_row(sst_pkg::ACT_FIND, KEY_HI, 0, sst_pkg::ST_OK, 1,
                                 33'h0040_1008, 33'h0040_1010, 1));
        // most negative frame, shadowing
        plan.push_back(known_row(sst_pkg::ACT_PUSH, KEY_HI, OFF_MIN, sst_pkg::ST_OK, 0, 0,
                                 0, 0));
        plan.push_back(known_row(sst_pkg::ACT_ADD, KEY_HI, OFF_MIN, sst_pkg::ST_OK, 0, 0,
                                 0, 0));
        plan.push_back(known_row(sst_pkg::ACT_FIND, KEY_HI, 0, sst_pkg::ST_OK, 0,
                                 33'h1_8000_0000, 0, 0));
        plan.push_back(known_row(sst_pkg::ACT_FIND, KEY_LO, 0, sst_pkg::ST_OK, 1,
                                 33'h0040_1000, 0, 0));
        // most positive frame
        plan.push_back(known_row(sst_pkg::ACT_PUSH, KEY_LO, OFF_MAX, sst_pkg::ST_OK, 0, 0,
                                 33'h0_7FFF_FFFF, 0));
        plan.push_back(step_row(sst_pkg::ACT_ADD, 64'h5555_5555_5555_5555, -1));
        plan.push_back(step_row(sst_pkg::ACT_ADD, KEY_HI, 0));
        plan.push_back(step_row(sst_pkg::ACT_FIND, KEY_HI, OFF_MAX));
        plan.push_back(step_row(sst_pkg::ACT_FIND, 64'h5555_5555_5555_5555, 0));
        plan.push_back(known_row(sst_pkg::ACT_PUSH, KEY_LO, -1, sst_pkg::ST_OK, 0, 0, 0, 0));
        plan.push_back(known_row(sst_pkg::ACT_PUSH, KEY_LO, 0, sst_pkg::ST_OK, 0, 0, 0, 0));
        plan.push_back(known_row(sst_pkg::ACT_PUSH, KEY_LO, 1, sst_pkg::ST_OK, 0, 0, 1, 0));
        plan.push_back(step_row(sst_pkg::ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 0));
        plan.push_back(step_row(sst_pkg::ACT_FIND, 64'h0123_4567_89AB_CDEF, 0));
        plan.push_back(step_row(sst_pkg::ACT_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 32'sh5A5A_A5A5));
        plan.push_back(step_row(sst_pkg::ACT_FIND, 64'hAAAA_AAAA_AAAA_AAAA, 0));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < plan.size(); i++)
            send_action(plan[i].action, plan[i].key, plan[i].offset, plan[i].typed,
                        plan[i].result);
        drain();

        write_base('0);
        run_random(600, 4, 45, 40);
        drain();

        write_base('1);
        run_random(600, 3, 30, 55);
        drain();

        // last part without idling
        idle_on = 1'b0;
        write_base(sst_pkg::GBASE_W'($urandom()));
        run_random(480, 3, 35, 50);
        drain();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
